// ===== rtl/core/preemptive_priority_scheduler_defines.svh =====
// Assertion macros shared by the checker of the preemptive priority scheduler.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pps_pkg.sv =====
// Package of types, constants and helper functions for the preemptive priority scheduler.
package pps_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
  localparam int TIME_W     = 24;
  localparam int VAL_W      = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_REPORT
  } pps_state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       slot;
    logic [VAL_W-1:0] priority_req;
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
  } pps_in_t;

  typedef struct packed {
    logic [3:0]        ran_slot;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] response_time;
    logic [TIME_W-1:0] turnaround_time;
  } pps_out_t;

  typedef struct packed {
    logic [VAL_W-1:0]  prio;
    logic [VAL_W-1:0]  arrival;
    logic [VAL_W-1:0]  remaining;
    logic [VAL_W-1:0]  burst;
    logic [TIME_W-1:0] first_start;
  } pps_rec_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    pps_rec_t          data;
  } pps_wr_t;

  function automatic logic [TIME_W-1:0] sub_clamp(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

// ===== rtl/core/pps_mem.sv =====
// Task table memory with one write port and one registered read port.
module pps_mem
  import pps_pkg::*;
(
  input  logic              clk,
  input  pps_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output pps_rec_t          rd_data
);

  pps_rec_t mem [TASK_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/pps_ctrl.sv =====
// Scheduler control: slot scan, read-modify-write of the chosen task and result timing.
module pps_ctrl
  import pps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pps_in_t           item,
  output logic              result_stb,
  output pps_out_t          result,
  output pps_wr_t           wr,
  output logic [SLOT_W-1:0] rd_addr,
  input  pps_rec_t          rd_data
);

  pps_state_t state, state_next;

  logic [CNT_W-1:0]      cnt;
  logic [SLOT_W-1:0]     slot_q;
  logic                  vld_q;
  logic [TASK_SLOTS-1:0] valid;
  logic [TASK_SLOTS-1:0] started;
  logic [TIME_W-1:0]     now_time;
  logic                  found;
  logic [SLOT_W-1:0]     best_slot;
  pps_rec_t              best_rec;
  logic                  fin_q;
  logic [TIME_W-1:0]     turn_q;
  logic [TIME_W-1:0]     resp_q;

  logic              accept;
  logic              load_ok;
  logic              cand_ok;
  logic              take;
  logic [TIME_W-1:0] done_time;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] arr_ext;

  assign accept    = start && !busy;
  assign load_ok   = 32'(item.slot) < TASK_SLOTS;
  assign done_time = (now_time != TIME_MAX) ? now_time + TIME_W'(1) : TIME_MAX;
  assign arr_ext   = TIME_W'(best_rec.arrival);
  assign start_time = started[best_slot] ? best_rec.first_start : now_time;
  assign rd_addr   = cnt[SLOT_W-1:0];

  assign cand_ok = vld_q && (rd_data.remaining != '0)
                   && (TIME_W'(rd_data.arrival) <= now_time);
  assign take    = (cnt != '0) && cand_ok && (!found || (rd_data.prio < best_rec.prio));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (item.kind == KIND_TICK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == CNT_W'(TASK_SLOTS)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_REPORT;
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    wr.en   = 1'b0;
    wr.addr = best_slot;
    wr.data = best_rec;
    case (state)
      ST_IDLE: begin
        busy    = 1'b0;
        wr.en   = start && (item.kind == KIND_LOAD) && load_ok;
        wr.addr = item.slot[SLOT_W-1:0];
        wr.data.prio        = item.priority_req;
        wr.data.arrival     = item.arrival;
        wr.data.remaining   = item.burst;
        wr.data.burst       = item.burst;
        wr.data.first_start = '0;
      end
      ST_UPDATE: begin
        wr.en                = found;
        wr.data.remaining   = best_rec.remaining - VAL_W'(1);
        wr.data.first_start = start_time;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      vld_q      <= 1'b0;
      valid      <= '0;
      started    <= '0;
      now_time   <= '0;
      found      <= 1'b0;
      fin_q      <= 1'b0;
      result_stb <= 1'b0;
    end else begin
      state      <= state_next;
      result_stb <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.kind)
              KIND_LOAD: begin
                if (load_ok) begin
                  valid[item.slot[SLOT_W-1:0]]   <= 1'b1;
                  started[item.slot[SLOT_W-1:0]] <= 1'b0;
                end
              end
              KIND_CLEAR: begin
                valid    <= '0;
                started  <= '0;
                now_time <= '0;
              end
              KIND_TICK: begin
                cnt   <= '0;
                found <= 1'b0;
              end
              default: begin
                found <= found;
              end
            endcase
          end
        end
        ST_SCAN: begin
          cnt    <= cnt + CNT_W'(1);
          slot_q <= cnt[SLOT_W-1:0];
          vld_q  <= (cnt != CNT_W'(TASK_SLOTS)) && valid[cnt[SLOT_W-1:0]];
          if (take) begin
            found     <= 1'b1;
            best_slot <= slot_q;
            best_rec  <= rd_data;
          end
        end
        ST_UPDATE: begin
          now_time <= done_time;
          fin_q    <= found && (best_rec.remaining == VAL_W'(1));
          turn_q   <= sub_clamp(done_time, arr_ext);
          resp_q   <= sub_clamp(done_time, start_time);
          if (found) begin
            started[best_slot] <= 1'b1;
          end
        end
        ST_REPORT: begin
          result_stb             <= 1'b1;
          result.ran_slot        <= found ? 4'(best_slot) : 4'd0;
          result.idle            <= !found;
          result.finished        <= fin_q;
          result.waiting_time    <= fin_q ? sub_clamp(turn_q, TIME_W'(best_rec.burst)) : '0;
          result.response_time   <= fin_q ? resp_q : '0;
          result.turnaround_time <= fin_q ? turn_q : '0;
        end
        default: begin
          result_stb <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// A load or clear transaction completes in the idle state and gives no result.
// A tick reads every task slot once through the table's single read port, then
// writes the chosen task back: its result strobes after the update and report states.
// A new tick is not taken while busy with the last; the receiver cannot stall the result.
// Reset clears the state machine, the slot valid and started flags and the time;
// the table memory is not swept, as invalid slots read as empty.
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  pps_in_t  item,
  output logic     result_stb,
  output pps_out_t result
);

  pps_wr_t           wr;
  logic [SLOT_W-1:0] rd_addr;
  pps_rec_t          rd_data;

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .result_stb (result_stb),
    .result     (result),
    .wr         (wr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  pps_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/core/pps_chk.sv =====
// Port-level checker for the preemptive priority scheduler, bound to the top level.
`include "preemptive_priority_scheduler_defines.svh"

module pps_chk
  import pps_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input pps_in_t  item,
  input logic     result_stb,
  input pps_out_t result
);

  `PPS_ASSERT_NEXT(a_tick_busy, start && !busy && (item.kind == KIND_TICK), busy, "tick transaction did not raise busy")
  `PPS_ASSERT_SAME(a_stb_idle, result_stb, !busy, "result shown while a tick is still in progress")
  `PPS_ASSERT_NEXT(a_stb_single, result_stb, !result_stb, "result strobe lasted more than one cycle")
  `PPS_ASSERT_SAME(a_idle_clean, result_stb && result.idle, !result.finished && (result.ran_slot == 4'd0) && (result.turnaround_time == '0), "idle tick reported a task")
  `PPS_ASSERT_SAME(a_wait_le_turn, result_stb && result.finished, result.waiting_time <= result.turnaround_time, "waiting time exceeds turnaround time")

endmodule

bind preemptive_priority_scheduler pps_chk u_pps_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .item       (item),
  .result_stb (result_stb),
  .result     (result)
);

// ===== tb/preemptive_priority_scheduler_checker.sv =====
// Checker for the preemptive priority scheduler: predicts every tick report and compares it.
module preemptive_priority_scheduler_checker
  import pps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  pps_in_t  item,
  input  logic     result_stb,
  input  pps_out_t result,
  output int       err_count,
  output int       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VAL_W-1:0]  prio_tab    [TASK_SLOTS];
  logic [VAL_W-1:0]  arrive_tab  [TASK_SLOTS];
  logic [VAL_W-1:0]  left_tab    [TASK_SLOTS];
  logic [VAL_W-1:0]  length_tab  [TASK_SLOTS];
  logic [TIME_W-1:0] first_tab   [TASK_SLOTS];
  bit                started_tab [TASK_SLOTS];
  logic [TIME_W-1:0] clock_now;

  pps_out_t tick_reports_q[$];
  pps_out_t want;
  int       fails = 0;

  function automatic logic [TIME_W-1:0] sat_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic wipe_table();
    for (int s = 0; s < TASK_SLOTS; s++) begin
      prio_tab[s]    = '0;
      arrive_tab[s]  = '0;
      left_tab[s]    = '0;
      length_tab[s]  = '0;
      first_tab[s]   = '0;
      started_tab[s] = 1'b0;
    end
    clock_now = '0;
  endtask

  task automatic serve_tick(output pps_out_t rep);
    int                best;
    bit                found;
    logic [TIME_W-1:0] done_t;
    logic [TIME_W-1:0] arr_t;
    best   = 0;
    found  = 1'b0;
    done_t = (clock_now == TIME_MAX) ? TIME_MAX : clock_now + 1'b1;
    for (int s = 0; s < TASK_SLOTS; s++) begin
      if (left_tab[s] != '0 && {8'd0, arrive_tab[s]} <= clock_now) begin
        if (!found || prio_tab[s] < prio_tab[best]) begin
          best  = s;
          found = 1'b1;
        end
      end
    end
    rep = '0;
    if (!found) begin
      rep.idle = 1'b1;
    end else begin
      if (!started_tab[best]) begin
        first_tab[best]   = clock_now;
        started_tab[best] = 1'b1;
      end
      left_tab[best] = left_tab[best] - 1'b1;
      rep.ran_slot   = 4'(best);
      if (left_tab[best] == '0) begin
        arr_t               = {8'd0, arrive_tab[best]};
        rep.finished        = 1'b1;
        rep.waiting_time    = sat_diff(sat_diff(done_t, arr_t), {8'd0, length_tab[best]});
        rep.response_time   = sat_diff(done_t, first_tab[best]);
        rep.turnaround_time = sat_diff(done_t, arr_t);
      end
    end
    clock_now = done_t;
  endtask

  task automatic check_field(input string field, input logic [TIME_W-1:0] exp_v,
                             input logic [TIME_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wipe_table();
      tick_reports_q.delete();
    end else begin
      if (result_stb) begin
        if (tick_reports_q.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h", $realtime, result);
          fails++;
        end else begin
          want = tick_reports_q.pop_front();
          check_field("ran_slot", TIME_W'(want.ran_slot), TIME_W'(result.ran_slot));
          check_field("idle", TIME_W'(want.idle), TIME_W'(result.idle));
          check_field("finished", TIME_W'(want.finished), TIME_W'(result.finished));
          check_field("waiting_time", want.waiting_time, result.waiting_time);
          check_field("response_time", want.response_time, result.response_time);
          check_field("turnaround_time", want.turnaround_time, result.turnaround_time);
        end
      end
      if (start && !busy) begin
        case (item.kind)
          KIND_LOAD: begin
            prio_tab[item.slot]    = item.priority_req;
            arrive_tab[item.slot]  = item.arrival;
            length_tab[item.slot]  = item.burst;
            left_tab[item.slot]    = item.burst;
            started_tab[item.slot] = 1'b0;
          end
          KIND_TICK: begin
            serve_tick(want);
            tick_reports_q.push_back(want);
          end
          KIND_CLEAR: begin
            wipe_table();
          end
          default: ;
        endcase
      end
    end
    err_count   <= fails;
    outstanding <= tick_reports_q.size();
  end

endmodule

// ===== tb/tb_preemptive_priority_scheduler.sv =====
// Testbench top for the preemptive priority scheduler: clock, reset, stimulus and verdict.
module tb_preemptive_priority_scheduler;
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  pps_in_t  item;
  logic     result_stb;
  pps_out_t result;
  int       err_count;
  int       outstanding;

  int sent;
  int ticks_since_clear;
  bit quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  preemptive_priority_scheduler u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .result_stb (result_stb),
    .result     (result)
  );

  preemptive_priority_scheduler_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_stb  (result_stb),
    .result      (result),
    .err_count   (err_count),
    .outstanding (outstanding)
  );

  function automatic pps_in_t pack_item(input logic [1:0] k, input logic [3:0] s,
                                        input logic [15:0] p, input logic [15:0] a,
                                        input logic [15:0] b);
    pps_in_t t;
    t.kind         = k;
    t.slot         = s;
    t.priority_req = p;
    t.arrival      = a;
    t.burst        = b;
    return t;
  endfunction

  task automatic issue(input pps_in_t t);
    if (!quiet && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (t.kind == KIND_TICK) begin
      ticks_since_clear++;
    end else if (t.kind == KIND_CLEAR) begin
      ticks_since_clear = 0;
    end
  endtask

  task automatic issue_tick();
    issue(pack_item(KIND_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
  endtask

  task automatic issue_random_load();
    logic [15:0] p;
    logic [15:0] a;
    logic [15:0] b;
    int          pick;
    p    = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    a    = ($urandom_range(9) == 0) ? 16'($urandom)
                                    : 16'(ticks_since_clear + $urandom_range(0, 6));
    pick = $urandom_range(19);
    if (pick == 0) begin
      b = '0;
    end else if (pick == 1) begin
      b = 16'($urandom);
    end else begin
      b = 16'($urandom_range(1, 6));
    end
    issue(pack_item(KIND_LOAD, 4'($urandom_range(0, 15)), p, a, b));
  endtask

  initial begin
    #2ms;
    $display("tb_preemptive_priority_scheduler: done, errors");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    item              = '0;
    sent              = 0;
    ticks_since_clear = 0;
    quiet             = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(pack_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 16'd0));
    issue(pack_item(KIND_LOAD, 4'd0, 16'hFFFF, 16'd0, 16'd1));
    issue(pack_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 16'd0));
    issue(pack_item(KIND_LOAD, 4'd15, 16'd0, 16'd0, 16'd2));
    issue(pack_item(KIND_LOAD, 4'd7, 16'd0, 16'd0, 16'd1));
    issue(pack_item(KIND_LOAD, 4'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    issue(pack_item(KIND_LOAD, 4'd5, 16'd0, 16'd0, 16'd0));
    repeat (3) issue(pack_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 16'd0));
    issue(pack_item(KIND_SPARE, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    issue(pack_item(KIND_LOAD, 4'd2, 16'd10, 16'd0, 16'd3));
    issue(pack_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 16'd0));
    issue(pack_item(KIND_LOAD, 4'd2, 16'd10, 16'd0, 16'd2));
    issue(pack_item(KIND_LOAD, 4'd1, 16'd20, 16'd0, 16'd3));
    issue(pack_item(KIND_LOAD, 4'd9, 16'd1, 16'(ticks_since_clear + 2), 16'd1));
    repeat (6) issue(pack_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 16'd0));
    issue(pack_item(KIND_CLEAR, 4'd0, 16'd0, 16'd0, 16'd0));
    issue(pack_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 16'd0));

    while (sent < 750) begin
      quiet = (sent >= 300 && sent < 450);
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 30) begin
          issue(pack_item(KIND_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom)));
        end
        repeat ($urandom_range(1, 6)) issue_random_load();
        repeat ($urandom_range(3, 20)) begin
          if ($urandom_range(99) < 10) begin
            issue_random_load();
          end
          issue_tick();
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          issue(pack_item(2'($urandom_range(0, 3)), 4'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom)));
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("tb_preemptive_priority_scheduler: done, clean");
    end else begin
      $display("tb_preemptive_priority_scheduler: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_mem.sv
rtl/core/pps_ctrl.sv
rtl/core/preemptive_priority_scheduler.sv
rtl/core/pps_chk.sv
tb/preemptive_priority_scheduler_checker.sv
tb/tb_preemptive_priority_scheduler.sv
